FILE: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Stable priority queue package
// Shared sizes, codes and types for the sorted-cell priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PRIO_W      = 32;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OCC_W       = 5;

  localparam int unsigned IN_TDATA_W  = PRIO_W + DATA_W;
  localparam int unsigned OUT_FIELD_W = PRIO_W + DATA_W + OCC_W;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] payload;
  } entry_t;

  // Command broadcast to every cell in the same cycle.
  typedef struct packed {
    logic   enq;
    logic   deq;
    entry_t item;
  } cmd_t;

endpackage

FILE: hw/rtl/stable_priority_queue_top.sv
// ----------------------------------------------------------------------------
// Stable priority queue top level
// Sorted row of cells; equal priorities leave in arrival order.
// ----------------------------------------------------------------------------
// An accepted request's result is loaded into the output register in the next
// cycle. Throughput: one request per cycle while m_axis_tready is high; the
// output register lets a new request enter while the previous result drains,
// but a held result stalls input. Reset empties the queue at once and clears
// the output valid; entry storage is not cleared.
module stable_priority_queue_top
  import spq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // priority_req[31:0], payload[63:32]
  input  logic                   s_axis_tuser,   // operation[0]
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // out_priority[31:0], out_payload[63:32],
                                                 // occupancy[68:64], zero fill above
  output logic [1:0]             m_axis_tuser    // status[1:0]
);

  logic             accept;
  logic             full, empty;
  cmd_t             cmd;
  logic [CNT_W-1:0] count_q, count_d;

  logic             out_valid_q;
  status_e          status_q, status_d;
  entry_t           out_entry_q, out_entry_d;

  logic   [QUEUE_DEPTH-1:0] le;
  entry_t                   cell_entry [QUEUE_DEPTH];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign full          = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty         = (count_q == '0);

  assign cmd.item.prio    = s_axis_tdata[PRIO_W-1:0];
  assign cmd.item.payload = s_axis_tdata[IN_TDATA_W-1:PRIO_W];
  assign cmd.enq          = accept && (op_e'(s_axis_tuser) == OP_ENQ) && !full;
  assign cmd.deq          = accept && (op_e'(s_axis_tuser) == OP_DEQ) && !empty;

  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic   left_le;
    entry_t left_entry, right_entry;

    if (g == 0) begin : g_head
      assign left_le    = 1'b1;
      assign left_entry = cmd.item;
    end else begin : g_body
      assign left_le    = le[g-1];
      assign left_entry = cell_entry[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign right_entry = cell_entry[g];
    end else begin : g_inner
      assign right_entry = cell_entry[g+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .valid_i       (CNT_W'(g) < count_q),
      .cmd_i         (cmd),
      .left_le_i     (left_le),
      .left_entry_i  (left_entry),
      .right_entry_i (right_entry),
      .le_o          (le[g]),
      .entry_o       (cell_entry[g])
    );
  end

  always_comb begin
    count_d     = count_q;
    status_d    = status_q;
    out_entry_d = out_entry_q;
    if (accept) begin
      out_entry_d = '0;
      if (op_e'(s_axis_tuser) == OP_ENQ) begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          status_d = ST_ENQ;
          count_d  = count_q + CNT_W'(1);
        end
      end else begin
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          status_d    = ST_DEQ;
          out_entry_d = cell_entry[0];
          count_d     = count_q - CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload; the occupancy shown is the count after the request.
  logic [CNT_W-1:0] occ_q;

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    out_entry_q <= out_entry_d;
    if (accept) begin
      occ_q <= count_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = OUT_TDATA_W'({OCC_W'(occ_q), out_entry_q.payload,
                                       out_entry_q.prio});

endmodule

FILE: hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Priority queue cell
// Holds one entry; on an insert it keeps, takes the new entry or takes its
// left neighbor, and on a removal it takes its right neighbor.
// ----------------------------------------------------------------------------
module spq_cell
  import spq_pkg::*;
(
  input  logic   clk_i,
  input  logic   valid_i,        // this cell lies below the fill level
  input  cmd_t   cmd_i,
  input  logic   left_le_i,      // left neighbor stays put on an insert
  input  entry_t left_entry_i,
  input  entry_t right_entry_i,
  output logic   le_o,
  output entry_t entry_o
);

  entry_t entry_q, entry_d;

  // A valid entry with priority not above the new one stays ahead of it.
  assign le_o    = valid_i && (entry_q.prio <= cmd_i.item.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.enq) begin
      if (!le_o) begin
        if (left_le_i) begin
          entry_d = cmd_i.item;
        end else begin
          entry_d = left_entry_i;
        end
      end
    end else if (cmd_i.deq) begin
      entry_d = right_entry_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
